>>> design/token_repetition_detector_defines.svh
// Assertion helpers for the token repetition detector.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef TOKEN_REPETITION_DETECTOR_DEFINES_SVH
`define TOKEN_REPETITION_DETECTOR_DEFINES_SVH

// Same-cycle implication.
`define TRD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/trd_pkg.sv
package trd_pkg;

  // held token count, saturating
  localparam int unsigned HELD_W   = 7;
  localparam int unsigned HELD_MAX = 127;
  // tokens needed before anything is flagged
  localparam int unsigned MIN_HELD = 6;

  // configuration port
  localparam int unsigned CFG_W     = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RUN_THRESHOLD_RST = 8;
  localparam int unsigned MAX_PERIOD_RST    = 24;

  localparam int unsigned PERIOD_OUT_W = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RUN_THRESHOLD = 1'b0,
    CFG_MAX_PERIOD    = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic                    cycle_hit;
    logic [PERIOD_OUT_W-1:0] period;
  } cycle_info_t;

  typedef struct packed {
    logic                    degenerate;
    logic                    run_hit;
    logic                    cycle_hit;
    logic [PERIOD_OUT_W-1:0] period_found;
  } result_t;

endpackage

>>> design/token_repetition_detector.sv
// The result of an item is registered and valid in the cycle after the item is accepted.
// Throughput: one item per cycle; every lag counter and the run counter update
// when the item is accepted, together with the result register.
// in_ready_o drops only while a result waits and out_ready_i is low.
// Reset clears the sequence state and loads run_threshold 8, max_period 24.
`include "token_repetition_detector_defines.svh"

module token_repetition_detector #(
  parameter int unsigned TOKEN_BITS    = 18,
  parameter int unsigned MAX_PERIOD    = 24,
  parameter int unsigned HISTORY_DEPTH = 72,
  parameter int unsigned RUN_WINDOW    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [trd_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [trd_pkg::CFG_W-1:0]           cfg_data_i,
  // input items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [TOKEN_BITS-1:0]               token_i,
  input  logic                                restart_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                degenerate_o,
  output logic                                run_hit_o,
  output logic                                cycle_hit_o,
  output logic [trd_pkg::PERIOD_OUT_W-1:0]    period_found_o
);
  import trd_pkg::*;

  // Only the last MAX_PERIOD tokens are ever compared against, and a lag
  // beyond the history depth never matches, so the shift line is the
  // shorter of the two.
  localparam int unsigned TAPS  = (HISTORY_DEPTH < MAX_PERIOD) ? HISTORY_DEPTH : MAX_PERIOD;
  localparam int unsigned RUN_W = $clog2(RUN_WINDOW + 1);
  localparam int unsigned CMP_W = (RUN_W > CFG_W) ? RUN_W : CFG_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] run_threshold_q;
  logic [CFG_W-1:0] max_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_threshold_q <= CFG_W'(RUN_THRESHOLD_RST);
      max_period_q    <= CFG_W'(MAX_PERIOD_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_RUN_THRESHOLD: run_threshold_q <= cfg_data_i;
        CFG_MAX_PERIOD:    max_period_q    <= cfg_data_i;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: one result register; a new item may enter in the same cycle
  // the waiting result leaves.
  // ---------------------------------------------------------------------------
  logic accept;
  logic out_valid_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Sequence state
  // ---------------------------------------------------------------------------
  logic [HELD_W-1:0] held_q, held_d;
  logic [HELD_W-1:0] prior;
  logic [RUN_W-1:0]  run_q, run_d;

  logic [TAPS-1:0][TOKEN_BITS-1:0] taps;
  logic [MAX_PERIOD-1:0]           full;
  cycle_info_t                     cyc_info;

  // restart drops the old sequence: the history taps are then never read
  // because every lag check requires the lag to be within the held count
  assign prior = restart_i ? '0 : held_q;

  always_comb begin
    held_d = restart_i                       ? HELD_W'(1) :
             (held_q == HELD_W'(HELD_MAX))   ? held_q :
                                               held_q + 1'b1;

    // trailing run of equal tokens, saturating at the window
    if ((prior != '0) && (taps[0] == token_i)) begin
      run_d = (run_q == RUN_W'(RUN_WINDOW)) ? run_q : run_q + 1'b1;
    end else begin
      run_d = RUN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      run_q  <= '0;
    end else if (accept) begin
      held_q <= held_d;
      run_q  <= run_d;
    end
  end

  trd_history #(
    .TOKEN_BITS (TOKEN_BITS),
    .TAPS       (TAPS)
  ) u_history (
    .clk_i   (clk_i),
    .shift_i (accept),
    .token_i (token_i),
    .taps_o  (taps)
  );

  trd_lag_bank #(
    .TOKEN_BITS (TOKEN_BITS),
    .MAX_PERIOD (MAX_PERIOD),
    .TAPS       (TAPS)
  ) u_lag_bank (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (accept),
    .token_i (token_i),
    .taps_i  (taps),
    .prior_i (prior),
    .full_o  (full)
  );

  trd_pick #(
    .MAX_PERIOD (MAX_PERIOD)
  ) u_pick (
    .full_i  (full),
    .limit_i (max_period_q),
    .info_o  (cyc_info)
  );

  // ---------------------------------------------------------------------------
  // Result
  // ---------------------------------------------------------------------------
  logic    armed;
  result_t res_d, res_q;

  // nothing is flagged until six tokens of the sequence are held
  assign armed = held_d >= HELD_W'(MIN_HELD);

  always_comb begin
    res_d.run_hit      = armed && (CMP_W'(run_d) >= CMP_W'(run_threshold_q));
    res_d.cycle_hit    = armed && cyc_info.cycle_hit;
    res_d.period_found = armed ? cyc_info.period : '0;
    res_d.degenerate   = res_d.run_hit || res_d.cycle_hit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign degenerate_o   = res_q.degenerate;
  assign run_hit_o      = res_q.run_hit;
  assign cycle_hit_o    = res_q.cycle_hit;
  assign period_found_o = res_q.period_found;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `TRD_ASSERT_NEXT(a_accept_gives_result, accept, out_valid_q, "accepted item left no result")
  `TRD_ASSERT_NEXT(a_restart_clears, accept && restart_i, held_q == 1 && run_q == 1, "restart did not clear the sequence")
  `TRD_ASSERT_NOW(a_period_matches_hit, out_valid_q, res_q.cycle_hit == (res_q.period_found != 0), "period_found disagrees with cycle_hit")
  `TRD_ASSERT_NOW(a_flag_needs_history, out_valid_q && res_q.degenerate, held_q >= MIN_HELD, "loop flagged with too few tokens held")

endmodule

>>> design/trd_history.sv
module trd_history #(
  parameter int unsigned TOKEN_BITS = 18,
  parameter int unsigned TAPS       = 24
) (
  input  logic                             clk_i,
  input  logic                             shift_i,
  input  logic [TOKEN_BITS-1:0]            token_i,
  output logic [TAPS-1:0][TOKEN_BITS-1:0]  taps_o
);

  // tap k holds the token k+1 places back
  logic [TAPS-1:0][TOKEN_BITS-1:0] taps_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      taps_q[0] <= token_i;
      for (int k = 1; k < TAPS; k++) begin
        taps_q[k] <= taps_q[k-1];
      end
    end
  end

  assign taps_o = taps_q;

endmodule

>>> design/trd_lag_bank.sv
module trd_lag_bank #(
  parameter int unsigned TOKEN_BITS = 18,
  parameter int unsigned MAX_PERIOD = 24,
  parameter int unsigned TAPS       = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    step_i,
  input  logic [TOKEN_BITS-1:0]                   token_i,
  input  logic [TAPS-1:0][TOKEN_BITS-1:0]         taps_i,
  input  logic [trd_pkg::HELD_W-1:0]              prior_i,
  output logic [MAX_PERIOD-1:0]                   full_o
);
  import trd_pkg::*;

  localparam int unsigned CNT_W = $clog2(2 * MAX_PERIOD + 1);

  logic [MAX_PERIOD-1:0]            match;
  logic [MAX_PERIOD-1:0][CNT_W-1:0] cnt_q, cnt_d;

  for (genvar p = 1; p <= MAX_PERIOD; p++) begin : g_lag
    if (p <= TAPS) begin : g_tap
      // lag p only counts once p tokens of this sequence are held
      assign match[p-1] = (prior_i >= HELD_W'(p)) && (taps_i[p-1] == token_i);
    end else begin : g_none
      assign match[p-1] = 1'b0;
    end

    // consecutive lag matches, saturating at 2p
    assign cnt_d[p-1] = !match[p-1]                    ? '0 :
                        (cnt_q[p-1] == CNT_W'(2 * p))  ? cnt_q[p-1] :
                                                         cnt_q[p-1] + 1'b1;
    assign full_o[p-1] = match[p-1] && (cnt_q[p-1] >= CNT_W'(2 * p - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> design/trd_pick.sv
module trd_pick #(
  parameter int unsigned MAX_PERIOD = 24
) (
  input  logic [MAX_PERIOD-1:0]       full_i,
  input  logic [trd_pkg::CFG_W-1:0]   limit_i,
  output trd_pkg::cycle_info_t        info_o
);
  import trd_pkg::*;

  localparam int unsigned PER_W = $clog2(MAX_PERIOD + 1);
  localparam int unsigned LIM_W = (PER_W > CFG_W) ? PER_W : CFG_W;

  logic [LIM_W-1:0] limit;

  assign limit = LIM_W'(limit_i);

  // smallest full period within the limit wins
  always_comb begin
    info_o = '0;
    for (int p = MAX_PERIOD; p >= 1; p--) begin
      if (full_i[p-1] && (LIM_W'(p) <= limit)) begin
        info_o.cycle_hit = 1'b1;
        info_o.period    = PERIOD_OUT_W'(p);
      end
    end
  end

endmodule
